[hw/rtl/tbh_pkg.sv]
// Shared widths, types and helpers of the triangle barycentric height block.
package tbh_pkg;

  localparam int COORD_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int VTX_BITS   = 3 * COORD_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int DOT_BITS   = PROD_BITS + 2;
  localparam int GRAM_BITS  = 2 * DOT_BITS + 1;
  localparam int QUO_BITS   = 32;
  localparam int NUM_BITS   = GRAM_BITS + WEIGHT_FRAC_BITS;
  localparam int CMP_BITS   = GRAM_BITS + QUO_BITS;
  localparam int WA_BITS    = QUO_BITS + 2;
  localparam int HSUM_BITS  = WA_BITS + COORD_BITS + 2;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;

  typedef struct packed {
    logic [VTX_BITS-1:0] a;
    logic [VTX_BITS-1:0] b;
    logic [VTX_BITS-1:0] c;
  } tri_t;

  // Pick one signed coordinate slice (0 = x, 1 = y, 2 = z) of a packed vertex.
  function automatic coord_t coord(input logic [VTX_BITS-1:0] v, input int k);
    return coord_t'(v[k*COORD_BITS +: COORD_BITS]);
  endfunction

  // Difference p - o with one bit of growth.
  function automatic diff_t diff(input coord_t o, input coord_t p);
    return diff_t'(p) - diff_t'(o);
  endfunction

endpackage

[hw/rtl/triangle_barycentric_height_top.sv]
// Top level: vertex registers, front stage, request queue and back pipeline.
//
//  channel   direction  handshake                 payload
//  query     in         push / full               query_x, query_y, query_z
//  result    out        pop / empty               height, weight_b, weight_c,
//                                                 inside_res, degenerate
//  config    in         psel, penable, pwrite     paddr, pwdata, prdata
//
// One query is taken per cycle while full is low. Its result reaches the ports
// after the front register, queue write, four product and Gram stages, 34 divider
// stages and two height stages.
// rst is synchronous and empties the front stage, queue and pipeline.
// A held result stalls the whole back pipeline; the four-entry queue and the
// front register keep taking queries until they fill, then full rises.
module triangle_barycentric_height_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  tbh_pkg::coord_t                      query_x,
  input  tbh_pkg::coord_t                      query_y,
  input  tbh_pkg::coord_t                      query_z,
  output logic                                 empty,
  input  logic                                 pop,
  output tbh_pkg::coord_t                      height,
  output logic signed [tbh_pkg::QUO_BITS-1:0]  weight_b,
  output logic signed [tbh_pkg::QUO_BITS-1:0]  weight_c,
  output logic                                 inside_res,
  output logic                                 degenerate,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [4:0]                           paddr,
  input  logic [63:0]                          pwdata,
  output logic [63:0]                          prdata,
  output logic                                 pready
);

  localparam logic [1:0] REG_VERTEX_A = 2'd0;
  localparam logic [1:0] REG_VERTEX_B = 2'd1;
  localparam logic [1:0] REG_VERTEX_C = 2'd2;

  tbh_pkg::tri_t tri_v;
  logic [1:0]    reg_idx;
  logic          wr;

  logic          fr_valid;
  tbh_pkg::vec_t fr_vec;
  logic          q_full;
  logic          q_empty;
  tbh_pkg::vec_t q_vec;
  logic          q_take;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr      = psel && penable && pwrite;

  // Vertex registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tri_v <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_VERTEX_A: tri_v.a <= pwdata[tbh_pkg::VTX_BITS-1:0];
        REG_VERTEX_B: tri_v.b <= pwdata[tbh_pkg::VTX_BITS-1:0];
        REG_VERTEX_C: tri_v.c <= pwdata[tbh_pkg::VTX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      REG_VERTEX_A: prdata = 64'(tri_v.a);
      REG_VERTEX_B: prdata = 64'(tri_v.b);
      REG_VERTEX_C: prdata = 64'(tri_v.c);
      default:      prdata = '0;
    endcase
  end

  tbh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .query_x   (query_x),
    .query_y   (query_y),
    .query_z   (query_z),
    .vtx_a     (tri_v.a),
    .out_valid (fr_valid),
    .out_vec   (fr_vec),
    .out_full  (q_full)
  );

  tbh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_valid),
    .wr_data (fr_vec),
    .full    (q_full),
    .rd_en   (q_take),
    .rd_data (q_vec),
    .empty   (q_empty)
  );

  tbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tri_v      (tri_v),
    .in_valid   (!q_empty),
    .in_vec     (q_vec),
    .in_take    (q_take),
    .pop        (pop),
    .empty      (empty),
    .height     (height),
    .weight_b   (weight_b),
    .weight_c   (weight_c),
    .inside_res (inside_res),
    .degenerate (degenerate)
  );

endmodule

[hw/rtl/tbh_front.sv]
// Front stage: takes query requests and forms the offset from vertex a.
module tbh_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  tbh_pkg::coord_t             query_x,
  input  tbh_pkg::coord_t             query_y,
  input  tbh_pkg::coord_t             query_z,
  input  logic [tbh_pkg::VTX_BITS-1:0] vtx_a,
  output logic                        out_valid,
  output tbh_pkg::vec_t               out_vec,
  input  logic                        out_full
);

  logic drain;
  logic accept;

  assign drain  = out_valid && !out_full;
  assign full   = out_valid && out_full;
  assign accept = push && !full;

  // Hold the offset until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_vec.x <= tbh_pkg::diff(tbh_pkg::coord(vtx_a, 0), query_x);
      out_vec.y <= tbh_pkg::diff(tbh_pkg::coord(vtx_a, 1), query_y);
      out_vec.z <= tbh_pkg::diff(tbh_pkg::coord(vtx_a, 2), query_z);
    end
  end

endmodule

[hw/rtl/tbh_queue.sv]
// Short request queue between the front stage and the arithmetic pipeline.
module tbh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  tbh_pkg::vec_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output tbh_pkg::vec_t rd_data,
  output logic          empty
);

  tbh_pkg::vec_t                       slots [tbh_pkg::QUEUE_DEPTH];
  logic [tbh_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr;
  logic [tbh_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr;
  logic [tbh_pkg::QUEUE_PTR_BITS:0]    count;
  logic                                do_wr;
  logic                                do_rd;

  assign full    = count == (tbh_pkg::QUEUE_PTR_BITS+1)'(tbh_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

[hw/rtl/tbh_div.sv]
// Pipelined restoring divider for both weights, one quotient bit per stage.
module tbh_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [tbh_pkg::GRAM_BITS-1:0] num_b,
  input  logic signed [tbh_pkg::GRAM_BITS-1:0] num_c,
  input  logic signed [tbh_pkg::GRAM_BITS-1:0] den,
  input  logic                                 in_degen,
  output logic                                 out_valid,
  output logic signed [tbh_pkg::QUO_BITS-1:0]  out_wb,
  output logic signed [tbh_pkg::QUO_BITS-1:0]  out_wc,
  output logic                                 out_degen
);

  localparam int G = tbh_pkg::GRAM_BITS;
  localparam int Q = tbh_pkg::QUO_BITS;
  localparam int F = tbh_pkg::WEIGHT_FRAC_BITS;
  localparam logic [Q-1:0] POS_MAX = {1'b0, {(Q-1){1'b1}}};
  localparam logic [Q-1:0] NEG_MAX = {1'b1, {(Q-1){1'b0}}};

  logic [G-1:0] rem   [2][Q+1];
  logic [Q-1:0] low   [2][Q+1];
  logic [Q-1:0] quo   [2][Q+1];
  logic         neg   [2][Q+1];
  logic         ovf   [2][Q+1];
  logic [G-1:0] den_s [Q+1];
  logic         vld   [Q+1];
  logic         dgn   [Q+1];
  logic signed [Q-1:0] wsat [2];

  // Take magnitudes, test for quotient overflow, load the top remainder
  for (genvar l = 0; l < 2; l++) begin : g_prep
    logic signed [G-1:0] num;
    logic [G-1:0]        mag;
    logic [tbh_pkg::NUM_BITS-1:0] mag_sh;
    assign num    = (l == 0) ? num_b : num_c;
    assign mag    = num[G-1] ? G'(-num) : G'(num);
    assign mag_sh = {mag, {F{1'b0}}};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[l][0] <= G'(mag_sh >> Q);
        low[l][0] <= mag_sh[Q-1:0];
        quo[l][0] <= '0;
        neg[l][0] <= num[G-1];
        ovf[l][0] <= tbh_pkg::CMP_BITS'(mag_sh) >= {den, {Q{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s[0] <= den;
      dgn[0]   <= in_degen;
    end
  end

  // One trial subtract per stage, quotient shifts in at the bottom
  for (genvar j = 0; j < Q; j++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [G-1:0] trial;
      logic         fits;
      assign trial = {rem[l][j][G-2:0], low[l][j][Q-1-j]};
      assign fits  = trial >= den_s[j];
      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][j+1] <= fits ? trial - den_s[j] : trial;
          quo[l][j+1] <= {quo[l][j][Q-2:0], fits};
          low[l][j+1] <= low[l][j];
          neg[l][j+1] <= neg[l][j];
          ovf[l][j+1] <= ovf[l][j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[j+1] <= den_s[j];
        dgn[j+1]   <= dgn[j];
      end
    end
  end

  // Apply sign and saturate to the 32-bit range
  for (genvar l = 0; l < 2; l++) begin : g_sat
    always_comb begin
      if (neg[l][Q]) begin
        if (ovf[l][Q] || quo[l][Q] > NEG_MAX) wsat[l] = NEG_MAX;
        else wsat[l] = -quo[l][Q];
      end else begin
        if (ovf[l][Q] || quo[l][Q] > POS_MAX) wsat[l] = POS_MAX;
        else wsat[l] = quo[l][Q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_wb    <= wsat[0];
      out_wc    <= wsat[1];
      out_degen <= dgn[Q];
    end
  end

endmodule

[hw/rtl/tbh_back.sv]
// Back pipeline: dot products, Gram terms, division and height interpolation.
module tbh_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tbh_pkg::tri_t                        tri_v,
  input  logic                                 in_valid,
  input  tbh_pkg::vec_t                        in_vec,
  output logic                                 in_take,
  input  logic                                 pop,
  output logic                                 empty,
  output tbh_pkg::coord_t                      height,
  output logic signed [tbh_pkg::QUO_BITS-1:0]  weight_b,
  output logic signed [tbh_pkg::QUO_BITS-1:0]  weight_c,
  output logic                                 inside_res,
  output logic                                 degenerate
);

  localparam int CW = tbh_pkg::COORD_BITS;
  localparam int F  = tbh_pkg::WEIGHT_FRAC_BITS;
  localparam int HS = tbh_pkg::HSUM_BITS;
  localparam logic signed [tbh_pkg::WA_BITS-1:0] WEIGHT_ONE =
    {{(tbh_pkg::WA_BITS-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  typedef logic signed [tbh_pkg::PROD_BITS-1:0] prod_t;
  typedef logic signed [tbh_pkg::DOT_BITS-1:0]  dot_t;
  typedef logic signed [tbh_pkg::GRAM_BITS-1:0] gram_t;
  typedef logic signed [tbh_pkg::WA_BITS+CW-1:0] term_t;

  logic en;
  logic res_valid;

  tbh_pkg::diff_t v0 [3];
  tbh_pkg::diff_t v1 [3];
  tbh_pkg::diff_t v2 [3];

  logic  s1_valid;
  prod_t p00 [3];
  prod_t p01 [3];
  prod_t p11 [3];
  prod_t p20 [3];
  prod_t p21 [3];

  logic s2_valid;
  dot_t d00, d01, d11, d20, d21;

  logic  s3_valid;
  gram_t m0011, m0101, m1120, m0121, m0021, m0120;

  logic  s4_valid;
  gram_t den, num_b, num_c;
  logic  s4_degen;

  logic                               dv_valid;
  logic signed [tbh_pkg::QUO_BITS-1:0] dv_wb, dv_wc;
  logic                               dv_degen;

  logic signed [tbh_pkg::WA_BITS-1:0] wa_c;
  logic                               h1_valid;
  term_t                              ta, tb, tc;
  logic signed [tbh_pkg::QUO_BITS-1:0] h1_wb, h1_wc;
  logic                               h1_inside, h1_degen;

  logic signed [HS-1:0] hsum;
  logic signed [HS-1:0] hshift;
  logic                 hsat;
  tbh_pkg::coord_t      hval;

  // Whole pipeline moves while the result slot is free or being taken
  assign en      = !res_valid || pop;
  assign in_take = en && in_valid;
  assign empty   = !res_valid;

  always_comb begin
    v2[0] = in_vec.x;
    v2[1] = in_vec.y;
    v2[2] = in_vec.z;
    for (int k = 0; k < 3; k++) begin
      v0[k] = tbh_pkg::diff(tbh_pkg::coord(tri_v.a, k), tbh_pkg::coord(tri_v.b, k));
      v1[k] = tbh_pkg::diff(tbh_pkg::coord(tri_v.a, k), tbh_pkg::coord(tri_v.c, k));
    end
  end

  // Valid chain of the front half
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Component products, then the five dot products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p00[k] <= v0[k] * v0[k];
        p01[k] <= v0[k] * v1[k];
        p11[k] <= v1[k] * v1[k];
        p20[k] <= v2[k] * v0[k];
        p21[k] <= v2[k] * v1[k];
      end
      d00 <= dot_t'(p00[0]) + dot_t'(p00[1]) + dot_t'(p00[2]);
      d01 <= dot_t'(p01[0]) + dot_t'(p01[1]) + dot_t'(p01[2]);
      d11 <= dot_t'(p11[0]) + dot_t'(p11[1]) + dot_t'(p11[2]);
      d20 <= dot_t'(p20[0]) + dot_t'(p20[1]) + dot_t'(p20[2]);
      d21 <= dot_t'(p21[0]) + dot_t'(p21[1]) + dot_t'(p21[2]);
    end
  end

  // Gram products, then determinant and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      m0011 <= d00 * d11;
      m0101 <= d01 * d01;
      m1120 <= d11 * d20;
      m0121 <= d01 * d21;
      m0021 <= d00 * d21;
      m0120 <= d01 * d20;
      den      <= m0011 - m0101;
      num_b    <= m1120 - m0121;
      num_c    <= m0021 - m0120;
      s4_degen <= (m0011 - m0101) == '0;
    end
  end

  tbh_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .num_b     (num_b),
    .num_c     (num_c),
    .den       (den),
    .in_degen  (s4_degen),
    .out_valid (dv_valid),
    .out_wb    (dv_wb),
    .out_wc    (dv_wc),
    .out_degen (dv_degen)
  );

  assign wa_c = WEIGHT_ONE - tbh_pkg::WA_BITS'(dv_wb) - tbh_pkg::WA_BITS'(dv_wc);

  // Weighted vertex heights and the inside test
  always_ff @(posedge clk) begin
    if (en) begin
      ta        <= wa_c * tbh_pkg::coord(tri_v.a, 1);
      tb        <= dv_wb * tbh_pkg::coord(tri_v.b, 1);
      tc        <= dv_wc * tbh_pkg::coord(tri_v.c, 1);
      h1_wb     <= dv_wb;
      h1_wc     <= dv_wc;
      h1_inside <= (wa_c > 0) && (dv_wb > 0) && (dv_wc > 0);
      h1_degen  <= dv_degen;
    end
  end

  // Floor shift and saturate the height
  assign hsum   = HS'(ta) + HS'(tb) + HS'(tc);
  assign hshift = hsum >>> F;
  assign hsat   = !((&hshift[HS-1:CW-1]) || !(|hshift[HS-1:CW-1]));
  assign hval   = hsat ? {hshift[HS-1], {(CW-1){!hshift[HS-1]}}} : hshift[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      h1_valid  <= dv_valid;
      res_valid <= h1_valid;
    end
  end

  // Result slot; a flat triangle reports zeros
  always_ff @(posedge clk) begin
    if (en) begin
      height     <= h1_degen ? '0 : hval;
      weight_b   <= h1_degen ? '0 : h1_wb;
      weight_c   <= h1_degen ? '0 : h1_wc;
      inside_res <= !h1_degen && h1_inside;
      degenerate <= h1_degen;
    end
  end

endmodule
